[sv/rtz_pkg.sv]
// Shared types and constants for the affine texture rotozoom block.
// Holds the request/response payloads, the operation codes, the controller
// states and the command/status bundles. Depends on nothing.
package rtz_pkg;

   localparam int GROUPS_PER_ROW = 40;
   localparam int ROWS_PER_FRAME = 100;
   localparam int GROUP_W        = 6;
   localparam int ROW_W          = 7;
   localparam int TEX_AW         = 16;
   localparam int TEX_DEPTH      = 65536;
   localparam int TEXEL_W        = 8;
   localparam int ACC_W          = 24;
   localparam int POS_W          = 32;
   localparam int FRAC_BITS      = 16;
   localparam int GRAD_SHIFT     = 6;
   localparam int ROW_STEP_MUL   = 307;
   localparam int ROW_STEP_SHIFT = 8;
   localparam int SLOTS          = 4;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_GROUP = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        tex_addr;
      logic [7:0]         texel;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] angle_a;
      logic signed [15:0] angle_b;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel0;
      logic [7:0] pixel1;
      logic [7:0] pixel2;
      logic [7:0] pixel3;
      logic       row_end;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic       tex_write;
      logic       frame_start;
      logic       row_advance;
      logic       read_step;
      logic       capture;
      logic [1:0] cap_slot;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic frame_active;
      logic group_first;
      logic rsp_full;
   } stat_type;

endpackage

[sv/rtz_dpath.sv]
// Datapath of the rotozoom block: texture memory, frame setup, row and
// column stepping, address generation and the response register.
// Depends on rtz_pkg; driven by commands from rtz_ctrl.
module rtz_dpath (
   input  logic              clock,
   input  logic              reset,
   input  rtz_pkg::cmd_type  cmd,
   output rtz_pkg::stat_type stat,
   input  rtz_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rtz_pkg::rsp_type  rsp_data
);
   import rtz_pkg::*;

   logic [TEXEL_W-1:0] tex_mem_ff [TEX_DEPTH];
   logic [TEXEL_W-1:0] rdata_ff;
   logic [TEXEL_W-1:0] work_ff [SLOTS-1];

   logic [ACC_W-1:0]   acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [ACC_W-1:0]   step_a_ff, step_a_in, step_b_ff, step_b_in;
   logic [POS_W-1:0]   row_pos_x_ff, row_pos_x_in, row_pos_y_ff, row_pos_y_in;
   logic [POS_W-1:0]   row_step_x_ff, row_step_x_in, row_step_y_ff, row_step_y_in;
   logic               turned_ff, turned_in;
   logic [GROUP_W-1:0] group_idx_ff, group_idx_in;
   logic [ROW_W-1:0]   row_idx_ff, row_idx_in;
   logic               frame_active_ff, frame_active_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // frame setup terms
   logic [16:0]        sa, sb, abs_a, abs_b;
   logic [POS_W-1:0]   xadd, yadd, xpos, ypos;
   logic [POS_W-1:0]   gx, gy, px, py, neg_gx, prod_x, prod_y;
   logic               turn;

   // address path
   logic [ACC_W-1:0]   acc_a_nx, acc_b_nx;
   logic [TEX_AW-1:0]  base, offset, log_addr, rd_addr, mem_addr;

   logic row_last, frame_last;

   always_comb begin
      sa    = {req_data.angle_a[15], req_data.angle_a};
      sb    = {req_data.angle_b[15], req_data.angle_b};
      abs_a = sa[16] ? 17'(17'd0 - sa) : sa;
      abs_b = sb[16] ? 17'(17'd0 - sb) : sb;
      turn  = abs_b > abs_a;
      xadd  = {{(POS_W-16-GRAD_SHIFT){req_data.angle_b[15]}}, req_data.angle_b,
               {GRAD_SHIFT{1'b0}}};
      yadd  = {{(POS_W-16-GRAD_SHIFT){req_data.angle_a[15]}}, req_data.angle_a,
               {GRAD_SHIFT{1'b0}}};
      xpos  = {req_data.pos_x, {FRAC_BITS{1'b0}}};
      ypos  = {req_data.pos_y, {FRAC_BITS{1'b0}}};
      // turned view: gradients become (-yadd, xadd), position (-ypos, xpos)
      gx     = turn ? POS_W'(32'd0 - yadd) : xadd;
      gy     = turn ? xadd : yadd;
      px     = turn ? POS_W'(32'd0 - ypos) : xpos;
      py     = turn ? xpos : ypos;
      neg_gx = POS_W'(32'd0 - gx);
      prod_x = POS_W'(gx * POS_W'(ROW_STEP_MUL));
      prod_y = POS_W'(gy * POS_W'(ROW_STEP_MUL));
   end

   always_comb begin
      acc_a_nx = ACC_W'(acc_a_ff + step_a_ff);
      acc_b_nx = ACC_W'(acc_b_ff + step_b_ff);
      offset   = {acc_b_nx[ACC_W-1 -: 8], acc_a_nx[ACC_W-1 -: 8]};
      base     = {row_pos_y_ff[FRAC_BITS+7:FRAC_BITS], row_pos_x_ff[FRAC_BITS+7:FRAC_BITS]};
      log_addr = TEX_AW'(base + offset);
      // turned texture: column c, row r reads column r, row 255 - c
      rd_addr  = turned_ff ? {~log_addr[7:0], log_addr[15:8]} : log_addr;
      mem_addr = cmd.tex_write ? req_data.tex_addr : rd_addr;
   end

   assign row_last   = group_idx_ff == GROUP_W'(GROUPS_PER_ROW - 1);
   assign frame_last = row_idx_ff == ROW_W'(ROWS_PER_FRAME - 1);

   always_comb begin
      acc_a_in        = acc_a_ff;
      acc_b_in        = acc_b_ff;
      step_a_in       = step_a_ff;
      step_b_in       = step_b_ff;
      row_pos_x_in    = row_pos_x_ff;
      row_pos_y_in    = row_pos_y_ff;
      row_step_x_in   = row_step_x_ff;
      row_step_y_in   = row_step_y_ff;
      turned_in       = turned_ff;
      group_idx_in    = group_idx_ff;
      row_idx_in      = row_idx_ff;
      frame_active_in = frame_active_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;

      if (cmd.frame_start) begin
         turned_in       = turn;
         step_a_in       = gy[ACC_W-1:0];
         step_b_in       = neg_gx[ACC_W-1:0];
         row_step_x_in   = {{ROW_STEP_SHIFT{prod_x[POS_W-1]}}, prod_x[POS_W-1:ROW_STEP_SHIFT]};
         row_step_y_in   = {{ROW_STEP_SHIFT{prod_y[POS_W-1]}}, prod_y[POS_W-1:ROW_STEP_SHIFT]};
         row_pos_x_in    = px;
         row_pos_y_in    = py;
         acc_a_in        = '0;
         acc_b_in        = '0;
         group_idx_in    = '0;
         row_idx_in      = '0;
         frame_active_in = 1'b1;
      end
      if (cmd.row_advance) begin
         row_pos_x_in = POS_W'(row_pos_x_ff + row_step_x_ff);
         row_pos_y_in = POS_W'(row_pos_y_ff + row_step_y_ff);
         acc_a_in     = '0;
         acc_b_in     = '0;
      end
      if (cmd.read_step) begin
         acc_a_in = acc_a_nx;
         acc_b_in = acc_b_nx;
      end
      if (cmd.finish) begin
         rsp_valid_in     = 1'b1;
         rsp_in.pixel0    = work_ff[0];
         rsp_in.pixel1    = work_ff[2];
         rsp_in.pixel2    = work_ff[1];
         rsp_in.pixel3    = rdata_ff;
         rsp_in.row_end   = row_last;
         rsp_in.frame_end = row_last && frame_last;
         if (row_last) begin
            group_idx_in = '0;
            if (frame_last) begin
               row_idx_in      = '0;
               frame_active_in = 1'b0;
            end else begin
               row_idx_in = ROW_W'(row_idx_ff + 1'b1);
            end
         end else begin
            group_idx_in = GROUP_W'(group_idx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_idx_ff    <= '0;
         row_idx_ff      <= '0;
         frame_active_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         group_idx_ff    <= group_idx_in;
         row_idx_ff      <= row_idx_in;
         frame_active_ff <= frame_active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_a_ff      <= acc_a_in;
      acc_b_ff      <= acc_b_in;
      step_a_ff     <= step_a_in;
      step_b_ff     <= step_b_in;
      row_pos_x_ff  <= row_pos_x_in;
      row_pos_y_ff  <= row_pos_y_in;
      row_step_x_ff <= row_step_x_in;
      row_step_y_ff <= row_step_y_in;
      turned_ff     <= turned_in;
      rsp_ff        <= rsp_in;
      if (cmd.capture) begin
         work_ff[cmd.cap_slot] <= rdata_ff;
      end
   end

   // single-port texture memory
   always_ff @(posedge clock) begin
      if (cmd.tex_write) begin
         tex_mem_ff[mem_addr] <= req_data.texel;
      end else if (cmd.read_step) begin
         rdata_ff <= tex_mem_ff[mem_addr];
      end
   end

   assign stat.frame_active = frame_active_ff;
   assign stat.group_first  = group_idx_ff == '0;
   assign stat.rsp_full     = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      group_idx_ff < GROUP_W'(GROUPS_PER_ROW))
      else $error("group index out of range");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_idx_ff < ROW_W'(ROWS_PER_FRAME))
      else $error("row index out of range");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      $fell(frame_active_ff) |-> $past(reset) ||
         $past(cmd.finish && row_last && frame_last))
      else $error("frame ended away from its last group");
`endif

endmodule

[sv/rtz_ctrl.sv]
// Controller of the rotozoom block: request intake and the per-group
// sequence of row setup, four texture reads and response load.
// Depends on rtz_pkg; commands rtz_dpath.
module rtz_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_op,
   output logic              req_ready,
   input  logic              rsp_ready,
   input  rtz_pkg::stat_type stat,
   output rtz_pkg::cmd_type  cmd
);
   import rtz_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] slot_ff, slot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op)
                  OP_WRITE: cmd.tex_write   = 1'b1;
                  OP_START: cmd.frame_start = 1'b1;
                  OP_GROUP: begin
                     // drop the request when no frame runs
                     if (stat.frame_active) begin
                        state_in = ST_SETUP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            cmd.row_advance = stat.group_first;
            slot_in         = '0;
            state_in        = ST_READ;
         end
         ST_READ: begin
            cmd.read_step = 1'b1;
            // data of the previous slot's read is now registered
            cmd.capture   = slot_ff != 2'd0;
            cmd.cap_slot  = 2'(slot_ff - 2'd1);
            slot_in       = 2'(slot_ff + 2'd1);
            if (slot_ff == 2'(SLOTS - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            // hold until the response register frees up
            if (!stat.rsp_full || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_setup_to_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SETUP |=> state_ff == ST_READ && slot_ff == 2'd0)
      else $error("row setup not followed by first read");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == ST_IDLE)
      else $error("controller busy after loading response");

   a_busy_active: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> stat.frame_active)
      else $error("group in progress without an active frame");
`endif

endmodule

[sv/affine_texture_rotozoom.sv]
// Rotating and zooming view of a 256x256 wrapped texture. A write or start
// request, or one that is dropped, is done in the cycle that takes it. A group
// request passes through these steps: taking the request, the row setup, four texel
// reads, which the single read-or-write port of the texture memory serializes
// at one a cycle, and loading the response register; a next request is
// taken while a response waits, and the response load stalls only while the
// previous response is still untaken. Texture contents are undefined after
// reset until written.
module affine_texture_rotozoom (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rtz_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rtz_pkg::rsp_type rsp_data
);
   import rtz_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rtz_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rtz_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[verif/testbench.sv]
// Self-checking bench for affine_texture_rotozoom: writes texels ahead of the
// groups that read them, runs directed and random request streams, and checks
// every response in order. Depends on rtz_pkg and the block's top level.
module testbench;
   import rtz_pkg::*;

   localparam int          RESET_CYCLES    = 12;
   localparam int          CYCLE_LIMIT     = 200000;
   localparam int          SETTLE_CYCLES   = 20;
   localparam int          MAX_REPORTS     = 10;
   localparam int          ROW_GROUPS      = 40;
   localparam int          FRAME_ROWS      = 100;
   localparam int          TEX_ENTRIES     = 65536;
   localparam int          GRAD_SCALE      = 64;
   localparam logic [31:0] ROW_SCALE       = 32'd307;
   localparam int          ROW_SCALE_SHIFT = 8;
   localparam int          RANDOM_PER_MODE = 100;
   localparam logic [1:0]  OP_UNUSED       = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   affine_texture_rotozoom uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int failures      = 0;
   int cycle_count   = 0;
   int items_sent    = 0;

   // Mirror of the block's state
   logic [7:0]  tex_mirror [TEX_ENTRIES];
   bit          tex_written [TEX_ENTRIES];
   logic [23:0] col_acc_u, col_acc_v, col_step_u, col_step_v;
   logic [31:0] row_x, row_y, row_dx, row_dy;
   logic        view_turned   = 1'b0;
   int          grp_count     = 0;
   int          row_count     = 0;
   logic        frame_running = 1'b0;
   rsp_type     pending_groups [$];
   rsp_type     head_group;

   function automatic logic [31:0] scale_row_step(input logic [31:0] grad);
      logic [31:0] prod;
      prod = grad * ROW_SCALE;
      return $signed(prod) >>> ROW_SCALE_SHIFT;
   endfunction

   function automatic logic [15:0] texel_phys(input logic [15:0] addr);
      // turned view: column c, row r reads column r, row 255 - c
      return view_turned ? {8'd255 - addr[7:0], addr[15:8]} : addr;
   endfunction

   function automatic logic [7:0] texel_at(input logic [15:0] addr);
      return tex_mirror[texel_phys(addr)];
   endfunction

   task automatic rotozoom_apply(input req_type rq);
      logic signed [31:0] xadd, yadd, mag_x, mag_y;
      logic [31:0]        gx, gy, px, py, swap;
      logic [15:0]        base;
      logic [15:0]        offs [4];
      rsp_type            want;
      case (rq.operation)
         OP_WRITE: begin
            tex_mirror[rq.tex_addr]  = rq.texel;
            tex_written[rq.tex_addr] = 1'b1;
         end
         OP_START: begin
            xadd  = GRAD_SCALE * $signed(rq.angle_b);
            yadd  = GRAD_SCALE * $signed(rq.angle_a);
            mag_x = (xadd < 0) ? -xadd : xadd;
            mag_y = (yadd < 0) ? -yadd : yadd;
            gx    = xadd;
            gy    = yadd;
            px    = {rq.pos_x, 16'h0000};
            py    = {rq.pos_y, 16'h0000};
            view_turned = (mag_x > mag_y);
            if (view_turned) begin
               swap = gx;
               gx   = -gy;
               gy   = swap;
               swap = px;
               px   = -py;
               py   = swap;
            end
            col_step_u    = gy[23:0];
            col_step_v    = 24'(-gx);
            row_dx        = scale_row_step(gx);
            row_dy        = scale_row_step(gy);
            row_x         = px;
            row_y         = py;
            col_acc_u     = '0;
            col_acc_v     = '0;
            grp_count     = 0;
            row_count     = 0;
            frame_running = 1'b1;
         end
         OP_GROUP: begin
            if (frame_running) begin
               if (grp_count == 0) begin
                  row_x     = row_x + row_dx;
                  row_y     = row_y + row_dy;
                  col_acc_u = '0;
                  col_acc_v = '0;
               end
               base = {row_y[23:16], row_x[23:16]};
               for (int s = 0; s < 4; s++) begin
                  col_acc_u = col_acc_u + col_step_u;
                  col_acc_v = col_acc_v + col_step_v;
                  offs[s]   = {col_acc_v[23:16], col_acc_u[23:16]};
               end
               want.pixel0    = texel_at(16'(base + offs[0]));
               want.pixel1    = texel_at(16'(base + offs[2]));
               want.pixel2    = texel_at(16'(base + offs[1]));
               want.pixel3    = texel_at(16'(base + offs[3]));
               want.row_end   = (grp_count + 1 >= ROW_GROUPS);
               want.frame_end = 1'b0;
               if (want.row_end) begin
                  grp_count = 0;
                  if (row_count + 1 >= FRAME_ROWS) begin
                     want.frame_end = 1'b1;
                     row_count      = 0;
                     frame_running  = 1'b0;
                  end else begin
                     row_count++;
                  end
               end else begin
                  grp_count++;
               end
               pending_groups.push_back(want);
            end
         end
         default: ;
      endcase
   endtask

   task automatic log_mismatch(input string what, input rsp_type want, input rsp_type got);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%s at cycle %0d: expected %h %h %h %h re=%b fe=%b, got %h %h %h %h re=%b fe=%b",
                  what, cycle_count, want.pixel0, want.pixel1, want.pixel2, want.pixel3,
                  want.row_end, want.frame_end, got.pixel0, got.pixel1, got.pixel2,
                  got.pixel3, got.row_end, got.frame_end);
   endtask

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_groups.size() == 0) begin
            log_mismatch("unexpected response", '0, rsp_data);
         end else begin
            head_group = pending_groups.pop_front();
            if (rsp_data.pixel0 !== head_group.pixel0 || rsp_data.pixel1 !== head_group.pixel1 ||
                rsp_data.pixel2 !== head_group.pixel2 || rsp_data.pixel3 !== head_group.pixel3 ||
                rsp_data.row_end !== head_group.row_end ||
                rsp_data.frame_end !== head_group.frame_end)
               log_mismatch("response mismatch", head_group, rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // The cycle limit stops a run that hangs and reports it as failed.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic send_request(input req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      rotozoom_apply(rq);
   endtask

   // Hold off the sender until every expected response has come back.
   task automatic wait_for_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_groups.size() != 0);
   endtask

   function automatic req_type random_fields(input logic [1:0] op);
      req_type rq;
      rq.operation = op;
      rq.tex_addr  = 16'($urandom);
      rq.texel     = 8'($urandom);
      rq.pos_x     = 16'($urandom);
      rq.pos_y     = 16'($urandom);
      rq.angle_a   = 16'($urandom);
      rq.angle_b   = 16'($urandom);
      return rq;
   endfunction

   task automatic start_view(input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] aa, input logic [15:0] ab);
      req_type rq;
      rq         = random_fields(OP_START);
      rq.pos_x   = px;
      rq.pos_y   = py;
      rq.angle_a = aa;
      rq.angle_b = ab;
      send_request(rq);
   endtask

   task automatic write_texel(input logic [15:0] addr, input logic [7:0] value);
      req_type rq;
      rq          = random_fields(OP_WRITE);
      rq.tex_addr = addr;
      rq.texel    = value;
      send_request(rq);
   endtask

   // Write every texel that the next group reads and that holds no value yet.
   task automatic fill_group_texels;
      logic [31:0] next_x, next_y;
      logic [23:0] acc_u, acc_v;
      logic [15:0] base, phys;
      if (frame_running) begin
         next_x = row_x;
         next_y = row_y;
         acc_u  = col_acc_u;
         acc_v  = col_acc_v;
         if (grp_count == 0) begin
            next_x = row_x + row_dx;
            next_y = row_y + row_dy;
            acc_u  = '0;
            acc_v  = '0;
         end
         base = {next_y[23:16], next_x[23:16]};
         for (int s = 0; s < 4; s++) begin
            acc_u = acc_u + col_step_u;
            acc_v = acc_v + col_step_v;
            phys  = texel_phys(16'(base + {acc_v[23:16], acc_u[23:16]}));
            if (!tex_written[phys]) write_texel(phys, 8'($urandom));
         end
      end
   endtask

   task automatic send_group;
      fill_group_texels;
      send_request(random_fields(OP_GROUP));
   endtask

   task automatic request_groups(input int count);
      for (int i = 0; i < count; i++) send_group;
   endtask

   task automatic random_start;
      req_type rq;
      int      va, vb;
      rq = random_fields(OP_START);
      case ($urandom_range(2))
         0: ;
         1: begin
            va = int'($urandom_range(4095)) - 2048;
            vb = int'($urandom_range(4095)) - 2048;
            rq.angle_a = va[15:0];
            rq.angle_b = vb[15:0];
         end
         default: begin
            if ($urandom_range(1)) rq.angle_a = '0;
            else rq.angle_b = '0;
         end
      endcase
      send_request(rq);
   endtask

   task automatic check_ignored_requests;
      send_request(random_fields(OP_GROUP));
      send_request(random_fields(OP_UNUSED));
      wait_for_results;
   endtask

   task automatic check_view_setup;
      start_view(16'h7FFF, 16'h8000, 16'h8000, 16'h0000);
      request_groups(2);
      start_view(16'h8000, 16'h7FFF, 16'h0000, 16'h8000);
      request_groups(2);
      // equal magnitudes keep the normal view
      start_view(16'h0000, 16'h0000, 16'h7FFF, 16'h8001);
      request_groups(1);
      start_view(16'hFFFF, 16'h0001, 16'h0001, 16'h7FFF);
      request_groups(1);
      wait_for_results;
   endtask

   task automatic check_restart_and_overwrite;
      // zero angles: all four slots read the texel under the view centre
      start_view(16'd5, 16'd7, 16'h0000, 16'h0000);
      request_groups(2);
      write_texel(16'h0705, 8'hA5);
      request_groups(1);
      start_view(16'h1234, 16'hFEDC, 16'h0123, 16'hFF00);
      request_groups(2);
      wait_for_results;
   endtask

   task automatic check_row_end;
      int va, vb;
      va = int'($urandom_range(127)) - 64;
      vb = int'($urandom_range(127)) - 64;
      start_view(16'($urandom), 16'($urandom), va[15:0], vb[15:0]);
      // cross a row boundary so the row position advances once more
      request_groups(ROW_GROUPS + 2);
      wait_for_results;
   endtask

   task automatic check_random_mix(input int count);
      int stop_at;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (!frame_running || pick < 8) begin
            random_start;
         end else if (pick < 20) begin
            send_request(random_fields(OP_WRITE));
         end else if (pick < 24) begin
            send_request(random_fields(OP_UNUSED));
         end else begin
            send_group;
         end
         if ($urandom_range(49) == 0) wait_for_results;
      end
      wait_for_results;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_idling(29, 52);
      check_ignored_requests;
      check_view_setup;
      check_restart_and_overwrite;
      check_row_end;
      check_random_mix(RANDOM_PER_MODE);
      set_idling(52, 29);
      check_random_mix(RANDOM_PER_MODE);
      set_idling(0, 0);
      check_random_mix(RANDOM_PER_MODE);
      wait_for_results;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/rtz_pkg.sv
sv/rtz_dpath.sv
sv/rtz_ctrl.sv
sv/affine_texture_rotozoom.sv
verif/testbench.sv
